// File: sv/ppcc_pkg.sv
`default_nettype none
package ppcc_pkg;

   localparam int AW = 64;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int VEL_W = 32;
   localparam int GAIN_W = 16;
   localparam int LIM_W = 31;
   localparam int CSR_IDX_W = 2;

   localparam logic [GAIN_W-1:0] GAIN_RST = 16'd512;
   localparam logic [LIM_W-1:0]  MAX_SPEED_RST = 31'd131072;
   localparam logic [LIM_W-1:0]  TOL_RST = 31'd6554;
   localparam logic [LIM_W-1:0]  DEAD_BAND_RST = 31'd655;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_BAND = 2'd3;

   localparam logic [1:0] REQ_POS = 2'd0;
   localparam logic [1:0] REQ_TGT = 2'd1;
   localparam logic [1:0] REQ_STOP = 2'd2;
   localparam logic [1:0] REQ_TICK = 2'd3;

   localparam logic [1:0] ST_DRIVE = 2'd0;
   localparam logic [1:0] ST_CLAMP = 2'd1;
   localparam logic [1:0] ST_ARRIVED = 2'd2;
   localparam logic [1:0] ST_STOP = 2'd3;

   localparam logic [1:0] OP_MUL = 2'd0;
   localparam logic [1:0] OP_DIV = 2'd1;
   localparam logic [1:0] OP_SQRT = 2'd2;

   typedef struct packed {
      logic          start;
      logic [1:0]    op;
      logic [AW-1:0] a;
      logic [AW-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic          done;
      logic [AW-1:0] result;
   } alu_rsp_type;

endpackage
`default_nettype wire

// File: sv/ppcc_if.sv
`default_nettype none
interface ppcc_req_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    req_type;
   logic signed [COORD_WIDTH-1:0] coord_x;
   logic signed [COORD_WIDTH-1:0] coord_y;
   logic signed [COORD_WIDTH-1:0] coord_z;
   logic                          stop_request;
   modport source (output valid, req_type, coord_x, coord_y, coord_z, stop_request,
                   input ready);
   modport sink (input valid, req_type, coord_x, coord_y, coord_z, stop_request,
                 output ready);
endinterface

interface ppcc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic [1:0]         status;
   modport source (output valid, vel_x, vel_y, vel_z, status, input ready);
   modport sink (input valid, vel_x, vel_y, vel_z, status, output ready);
endinterface
`default_nettype wire

// File: sv/position_p_controller_clamp_core.sv
// Event-driven three-axis proportional position controller, Q16.16. Position, target and
// stop beats need no arithmetic. A control tick runs a shared bit-serial arithmetic unit
// (shift-add multiply, 32 steps; restoring divide, 64 steps; square root, 32 steps). A stop
// goes straight to the output register and an arrival follows the error check; an unclamped
// command follows the three gain multiplies and the squares; a clamped one may also need
// halving steps of the horizontal pair, then adds the square root and two multiply-divide
// pairs. That unit sets the rate. Beats are taken one at a time; a command left in the
// output register holds the next one in S_PUT, and no beat is taken meanwhile.
`default_nettype none
module position_p_controller_clamp_core
   import ppcc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   ppcc_req_if.sink                   req_bus,
   ppcc_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [LIM_W-1:0]      csr_wdata
);

   localparam int EW = COORD_WIDTH + 1;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ERR = 4'd1;
   localparam logic [3:0] S_MULG = 4'd2;
   localparam logic [3:0] S_SHIFT = 4'd3;
   localparam logic [3:0] S_SQA = 4'd4;
   localparam logic [3:0] S_SQB = 4'd5;
   localparam logic [3:0] S_SQM = 4'd6;
   localparam logic [3:0] S_SQRT = 4'd7;
   localparam logic [3:0] S_MULX = 4'd8;
   localparam logic [3:0] S_DIVX = 4'd9;
   localparam logic [3:0] S_MULY = 4'd10;
   localparam logic [3:0] S_DIVY = 4'd11;
   localparam logic [3:0] S_PUT = 4'd12;

   logic [GAIN_W-1:0] gain_ff;
   logic [LIM_W-1:0]  max_ff, tol_ff, db_ff;

   logic signed [COORD_WIDTH-1:0] target_ff [3];
   logic signed [COORD_WIDTH-1:0] target_in [3];
   logic signed [COORD_WIDTH-1:0] current_ff [3];
   logic signed [COORD_WIDTH-1:0] current_in [3];
   logic signed [COORD_WIDTH-1:0] coord [3];
   logic          have_ff, have_in;
   logic          stop_ff, stop_in;
   logic [3:0]    state_ff, state_in;
   logic          wait_ff, wait_in;
   logic [1:0]    axis_ff, axis_in;
   logic          shifted_ff, shifted_in;
   logic [AW-1:0] mag_ff [3];
   logic [AW-1:0] mag_in [3];
   logic [2:0]    neg_ff, neg_in;
   logic [AW-1:0] mx_ff, mx_in, my_ff, my_in, sum_ff, sum_in, h_ff, h_in;
   logic [1:0]    code_ff, code_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [VEL_W-1:0]  vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic [1:0]        status_ff, status_in;

   logic signed [EW-1:0] err [3];
   logic [EW-1:0]        emag [3];
   logic                 arrived;
   logic                 accept;
   logic                 put_go;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   ppcc_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign coord[0] = req_bus.coord_x;
   assign coord[1] = req_bus.coord_y;
   assign coord[2] = req_bus.coord_z;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept = req_bus.valid && req_bus.ready;
   assign put_go = (state_ff == S_PUT) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      arrived = 1'b1;
      for (int i = 0; i < 3; i++) begin
         err[i] = EW'(target_ff[i]) - EW'(current_ff[i]);
         emag[i] = err[i][EW-1] ? EW'(-err[i]) : EW'(err[i]);
         if (AW'(emag[i]) >= AW'(tol_ff)) begin
            arrived = 1'b0;
         end
      end
   end

   always_comb begin
      alu_req.start = 1'b0;
      alu_req.op = OP_MUL;
      alu_req.a = mx_ff;
      alu_req.b = AW'(max_ff);
      unique case (state_ff)
         S_MULG: begin
            alu_req.a = mag_ff[axis_ff];
            alu_req.b = AW'(gain_ff);
         end
         S_SQA: alu_req.b = mx_ff;
         S_SQB: begin
            alu_req.a = my_ff;
            alu_req.b = my_ff;
         end
         S_SQM: alu_req.a = AW'(max_ff);
         S_SQRT: begin
            alu_req.op = OP_SQRT;
            alu_req.a = sum_ff;
         end
         S_DIVX: begin
            alu_req.op = OP_DIV;
            alu_req.b = h_ff;
         end
         S_MULY: alu_req.a = my_ff;
         S_DIVY: begin
            alu_req.op = OP_DIV;
            alu_req.a = my_ff;
            alu_req.b = h_ff;
         end
         default: ;
      endcase
      if (state_ff >= S_MULG && state_ff <= S_DIVY && state_ff != S_SHIFT) begin
         alu_req.start = !wait_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      wait_in = wait_ff;
      axis_in = axis_ff;
      shifted_in = shifted_ff;
      have_in = have_ff;
      stop_in = stop_ff;
      neg_in = neg_ff;
      mx_in = mx_ff;
      my_in = my_ff;
      sum_in = sum_ff;
      h_in = h_ff;
      code_in = code_ff;
      for (int i = 0; i < 3; i++) begin
         target_in[i] = target_ff[i];
         current_in[i] = current_ff[i];
         mag_in[i] = mag_ff[i];
      end
      if (alu_req.start) begin
         wait_in = 1'b1;
      end
      if (alu_rsp.done) begin
         wait_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_bus.req_type)
                  REQ_POS: begin
                     for (int i = 0; i < 3; i++) begin
                        current_in[i] = coord[i];
                        if (!have_ff) begin
                           target_in[i] = coord[i];
                        end
                     end
                     have_in = 1'b1;
                  end
                  REQ_TGT: begin
                     if (!stop_ff) begin
                        for (int i = 0; i < 3; i++) begin
                           target_in[i] = coord[i];
                        end
                     end
                  end
                  REQ_STOP: begin
                     stop_in = req_bus.stop_request;
                     if (req_bus.stop_request && !stop_ff) begin
                        code_in = ST_STOP;
                        state_in = S_PUT;
                     end
                  end
                  default: begin
                     if (stop_ff) begin
                        code_in = ST_STOP;
                        state_in = S_PUT;
                     end else if (have_ff) begin
                        state_in = S_ERR;
                     end
                  end
               endcase
               mx_in = '0;
               my_in = '0;
               neg_in = '0;
               mag_in[2] = '0;
            end
         end
         S_ERR: begin
            if (arrived) begin
               code_in = ST_ARRIVED;
               state_in = S_PUT;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = err[i][EW-1];
                  mag_in[i] = (AW'(emag[i]) < AW'(db_ff)) ? '0 : AW'(emag[i]);
               end
               axis_in = 2'd0;
               state_in = S_MULG;
            end
         end
         S_MULG: begin
            if (alu_rsp.done) begin
               mag_in[axis_ff] = alu_rsp.result >> 8;
               axis_in = axis_ff + 2'd1;
               if (axis_ff == 2'd2) begin
                  mx_in = mag_ff[0];
                  my_in = mag_ff[1];
                  shifted_in = 1'b0;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            if ((mx_ff | my_ff) >= (AW'(1) << LIM_W)) begin
               mx_in = mx_ff >> 1;
               my_in = my_ff >> 1;
               shifted_in = 1'b1;
            end else begin
               state_in = S_SQA;
            end
         end
         S_SQA: begin
            if (alu_rsp.done) begin
               sum_in = alu_rsp.result;
               state_in = S_SQB;
            end
         end
         S_SQB: begin
            if (alu_rsp.done) begin
               sum_in = sum_ff + alu_rsp.result;
               state_in = S_SQM;
            end
         end
         S_SQM: begin
            if (alu_rsp.done) begin
               if (shifted_ff || sum_ff > alu_rsp.result) begin
                  state_in = S_SQRT;
               end else begin
                  code_in = ST_DRIVE;
                  state_in = S_PUT;
               end
            end
         end
         S_SQRT: begin
            if (alu_rsp.done) begin
               h_in = (alu_rsp.result == '0) ? AW'(1) : alu_rsp.result;
               state_in = S_MULX;
            end
         end
         S_MULX: begin
            if (alu_rsp.done) begin
               mx_in = alu_rsp.result;
               state_in = S_DIVX;
            end
         end
         S_DIVX: begin
            if (alu_rsp.done) begin
               mx_in = alu_rsp.result;
               state_in = S_MULY;
            end
         end
         S_MULY: begin
            if (alu_rsp.done) begin
               my_in = alu_rsp.result;
               state_in = S_DIVY;
            end
         end
         S_DIVY: begin
            if (alu_rsp.done) begin
               my_in = alu_rsp.result;
               code_in = ST_CLAMP;
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            if (put_go) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      vz_in = vz_ff;
      status_in = status_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (put_go) begin
         rsp_valid_in = 1'b1;
         status_in = code_ff;
         vx_in = neg_ff[0] ? (~mx_ff[VEL_W-1:0] + 1'b1) : mx_ff[VEL_W-1:0];
         vy_in = neg_ff[1] ? (~my_ff[VEL_W-1:0] + 1'b1) : my_ff[VEL_W-1:0];
         if (neg_ff[2]) begin
            vz_in = (mag_ff[2] > (AW'(1) << (VEL_W - 1))) ? {1'b1, {(VEL_W-1){1'b0}}}
                                                         : (~mag_ff[2][VEL_W-1:0] + 1'b1);
         end else begin
            vz_in = (mag_ff[2] > AW'({(VEL_W-1){1'b1}})) ? {1'b0, {(VEL_W-1){1'b1}}}
                                                        : mag_ff[2][VEL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff <= 1'b0;
         have_ff <= 1'b0;
         stop_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gain_ff <= GAIN_RST;
         max_ff <= MAX_SPEED_RST;
         tol_ff <= TOL_RST;
         db_ff <= DEAD_BAND_RST;
         for (int i = 0; i < 3; i++) begin
            target_ff[i] <= '0;
            current_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         wait_ff <= wait_in;
         have_ff <= have_in;
         stop_ff <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 3; i++) begin
            target_ff[i] <= target_in[i];
            current_ff[i] <= current_in[i];
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_GAIN:      gain_ff <= csr_wdata[GAIN_W-1:0];
               CSR_MAX_SPEED: max_ff <= csr_wdata;
               CSR_TOL:       tol_ff <= csr_wdata;
               default:       db_ff <= csr_wdata;
            endcase
         end
      end
      axis_ff <= axis_in;
      shifted_ff <= shifted_in;
      neg_ff <= neg_in;
      mx_ff <= mx_in;
      my_ff <= my_in;
      sum_ff <= sum_in;
      h_ff <= h_in;
      code_ff <= code_in;
      for (int i = 0; i < 3; i++) begin
         mag_ff[i] <= mag_in[i];
      end
      vx_ff <= vx_in;
      vy_ff <= vy_in;
      vz_ff <= vz_in;
      status_ff <= status_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.vel_x = vx_ff;
   assign rsp_bus.vel_y = vy_ff;
   assign rsp_bus.vel_z = vz_ff;
   assign rsp_bus.status = status_ff;

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset) alu_rsp.done |-> wait_ff)
      else $error("arithmetic unit finished with no operation pending");
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.status == ST_ARRIVED || rsp_bus.status == ST_STOP)
      |-> rsp_bus.vel_x == '0 && rsp_bus.vel_y == '0 && rsp_bus.vel_z == '0)
      else $error("arrival or stop beat carries a nonzero command");
   assert property (@(posedge clock) disable iff (reset) have_ff |=> have_ff)
      else $error("pose flag dropped without reset");
   assert property (@(posedge clock) disable iff (reset)
      put_go |=> rsp_bus.valid && state_ff == S_IDLE)
      else $error("command not loaded into output register");
`endif

endmodule
`default_nettype wire

// File: sv/ppcc_alu.sv
`default_nettype none
module ppcc_alu
   import ppcc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire alu_req_type alu_req,
   output alu_rsp_type      alu_rsp
);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [1:0]    op_ff, op_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [AW-1:0] x_ff, x_in;
   logic [AW-1:0] y_ff, y_in;
   logic [AW:0]   rem2;
   logic [AW-1:0] sq_t;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in = op_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      x_in = x_ff;
      y_in = y_ff;
      rem2 = {acc_ff, x_ff[AW-1]};
      sq_t = y_ff + x_ff;
      if (!busy_ff && alu_req.start) begin
         busy_in = 1'b1;
         op_in = alu_req.op;
         unique case (alu_req.op)
            OP_MUL: begin
               acc_in = '0;
               x_in = alu_req.a;
               y_in = alu_req.b;
               cnt_in = 6'd31;
            end
            OP_DIV: begin
               acc_in = '0;
               x_in = alu_req.a;
               y_in = alu_req.b;
               cnt_in = 6'd63;
            end
            default: begin
               acc_in = alu_req.a;
               x_in = AW'(1) << (AW - 2);
               y_in = '0;
               cnt_in = 6'd31;
            end
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            OP_MUL: begin
               if (y_ff[0]) begin
                  acc_in = acc_ff + x_ff;
               end
               x_in = x_ff << 1;
               y_in = y_ff >> 1;
            end
            OP_DIV: begin
               if (rem2 >= {1'b0, y_ff}) begin
                  acc_in = AW'(rem2 - {1'b0, y_ff});
                  x_in = {x_ff[AW-2:0], 1'b1};
               end else begin
                  acc_in = rem2[AW-1:0];
                  x_in = {x_ff[AW-2:0], 1'b0};
               end
            end
            default: begin
               if (acc_ff >= sq_t) begin
                  acc_in = acc_ff - sq_t;
                  y_in = (y_ff >> 1) + x_ff;
               end else begin
                  y_in = y_ff >> 1;
               end
               x_in = x_ff >> 2;
            end
         endcase
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff <= x_in;
      y_ff <= y_in;
   end

   always_comb begin
      alu_rsp.done = done_ff;
      unique case (op_ff)
         OP_MUL:  alu_rsp.result = acc_ff;
         OP_DIV:  alu_rsp.result = x_ff;
         default: alu_rsp.result = y_ff;
      endcase
   end

endmodule
`default_nettype wire

// File: test/position_p_controller_clamp_core_tb.sv
`default_nettype none
module position_p_controller_clamp_core_tb;
   import ppcc_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 600;
   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 200;

   typedef struct {
      logic [1:0]         kind;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               stop;
   } event_type;

   typedef struct {
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic [1:0]         status;
   } vel_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_GAIN;
   logic [LIM_W-1:0] csr_wdata = '0;

   ppcc_req_if #(.COORD_WIDTH(32)) req_bus ();
   ppcc_rsp_if rsp_bus ();

   position_p_controller_clamp_core #(.COORD_WIDTH(32)) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   event_type pending_events[$];
   vel_cmd_type expected_cmds[$];
   event_type offered;
   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit hold_request = 0;
   bit send_quiet = 0;
   bit recv_quiet = 0;
   int mismatches = 0;
   int cycles = 0;

   logic [GAIN_W-1:0] k_gain;
   logic [LIM_W-1:0] v_max;
   logic [LIM_W-1:0] arrive_tol;
   logic [LIM_W-1:0] dband;
   logic signed [31:0] tgt_pos[3];
   logic signed [31:0] cur_pos[3];
   bit pose_valid;
   bit estop;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.req_type = REQ_POS;
      req_bus.coord_x = '0;
      req_bus.coord_y = '0;
      req_bus.coord_z = '0;
      req_bus.stop_request = 1'b0;
      rsp_bus.ready = 1'b0;
   end

   function automatic longint unsigned isqrt(input longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic bit control_step(input event_type ev, output vel_cmd_type cmd);
      longint e;
      longint unsigned mag[3];
      bit neg[3];
      bit arrived;
      longint unsigned mx, my, a, b, sum, h, vm;
      int s;
      bit prev;
      cmd = '{0, 0, 0, ST_DRIVE};
      case (ev.kind)
         REQ_POS: begin
            cur_pos = '{ev.x, ev.y, ev.z};
            if (!pose_valid) begin
               tgt_pos = cur_pos;
               pose_valid = 1;
            end
            return 0;
         end
         REQ_TGT: begin
            if (!estop) tgt_pos = '{ev.x, ev.y, ev.z};
            return 0;
         end
         REQ_STOP: begin
            prev = estop;
            estop = ev.stop;
            if (estop && !prev) begin
               cmd.status = ST_STOP;
               return 1;
            end
            return 0;
         end
         default: begin
            if (estop) begin
               cmd.status = ST_STOP;
               return 1;
            end
            if (!pose_valid) return 0;
            arrived = 1;
            for (int i = 0; i < 3; i++) begin
               e = longint'(tgt_pos[i]) - longint'(cur_pos[i]);
               neg[i] = e < 0;
               mag[i] = neg[i] ? -e : e;
               if (mag[i] >= arrive_tol) arrived = 0;
            end
            if (arrived) begin
               cmd.status = ST_ARRIVED;
               return 1;
            end
            for (int i = 0; i < 3; i++)
               mag[i] = (mag[i] < dband) ? 0 : (mag[i] * k_gain) >> 8;
            mx = mag[0];
            my = mag[1];
            vm = v_max;
            s = 0;
            while (((mx >> s) | (my >> s)) >= (64'd1 << 31)) s++;
            a = mx >> s;
            b = my >> s;
            sum = a * a + b * b;
            if (s > 0 || sum > vm * vm) begin
               h = isqrt(sum);
               if (h == 0) h = 1;
               mx = a * vm / h;
               my = b * vm / h;
               cmd.status = ST_CLAMP;
            end
            cmd.vx = neg[0] ? -mx : mx;
            cmd.vy = neg[1] ? -my : my;
            if (neg[2])
               cmd.vz = (mag[2] > 64'h8000_0000) ? 32'sh8000_0000 : -mag[2];
            else
               cmd.vz = (mag[2] > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : mag[2];
            return 1;
         end
      endcase
   endfunction

   function automatic int pick_gap(inout bit quiet);
      int r;
      if ($urandom_range(0, 149) == 0) quiet = !quiet;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   always @(posedge clock) begin
      vel_cmd_type cmd;
      bit offering;
      offering = req_bus.valid;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (control_step(offered, cmd)) expected_cmds.push_back(cmd);
            offering = 0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_events.size() > 0) begin
               offered = pending_events.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.req_type <= offered.kind;
               req_bus.coord_x <= offered.x;
               req_bus.coord_y <= offered.y;
               req_bus.coord_z <= offered.z;
               req_bus.stop_request <= offered.stop;
               gap_left = pick_gap(send_quiet);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 0;
         hold_left = 3000;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) stall_left = pick_gap(recv_quiet);
         rsp_bus.ready <= (stall_left == 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      vel_cmd_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_cmds.size() == 0) begin
            $display("%0t: unexpected beat vx=%0d vy=%0d vz=%0d status=%0d", $time,
                     rsp_bus.vel_x, rsp_bus.vel_y, rsp_bus.vel_z, rsp_bus.status);
            mismatches++;
         end else begin
            want = expected_cmds.pop_front();
            if (rsp_bus.vel_x !== want.vx) begin
               $display("%0t: vel_x expected %0d actual %0d", $time, want.vx, rsp_bus.vel_x);
               mismatches++;
            end
            if (rsp_bus.vel_y !== want.vy) begin
               $display("%0t: vel_y expected %0d actual %0d", $time, want.vy, rsp_bus.vel_y);
               mismatches++;
            end
            if (rsp_bus.vel_z !== want.vz) begin
               $display("%0t: vel_z expected %0d actual %0d", $time, want.vz, rsp_bus.vel_z);
               mismatches++;
            end
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_bus.status);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic add(input logic [1:0] kind, input logic signed [31:0] x,
                      input logic signed [31:0] y, input logic signed [31:0] z,
                      input logic stop);
      pending_events.push_back('{kind, x, y, z, stop});
   endtask

   function automatic logic signed [31:0] near(input logic signed [31:0] anchor);
      case ($urandom_range(0, 9))
         0, 9:    return $urandom;
         1, 2, 3: return anchor + $signed($urandom_range(0, 2000)) - 1000;
         4, 5, 6: return anchor + $signed($urandom & 32'h3FFFF) - 32'sh20000;
         default: return anchor + $signed($urandom & 32'h3FFFFFF) - 32'sh2000000;
      endcase
   endfunction

   task automatic add_random(input int count);
      logic signed [31:0] ax, ay, az;
      int r;
      ax = $urandom;
      ay = $urandom;
      az = $urandom;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 49) == 0) begin
            ax = $urandom;
            ay = $urandom;
            az = $urandom;
         end
         r = $urandom_range(0, 99);
         if (r < 30)
            add(REQ_POS, near(ax), near(ay), near(az), $urandom_range(0, 1));
         else if (r < 55)
            add(REQ_TGT, near(ax), near(ay), near(az), $urandom_range(0, 1));
         else if (r < 63)
            add(REQ_STOP, $urandom, $urandom, $urandom, $urandom_range(0, 3) == 0);
         else
            add(REQ_TICK, $urandom, $urandom, $urandom, $urandom_range(0, 1));
      end
   endtask

   task automatic settle();
      while (pending_events.size() > 0 || req_bus.valid || expected_cmds.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_GAIN:      k_gain = val[GAIN_W-1:0];
         CSR_MAX_SPEED: v_max = val;
         CSR_TOL:       arrive_tol = val;
         default:       dband = val;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   localparam logic signed [31:0] Q1 = 32'sh10000;
   localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] PMIN = 32'sh8000_0000;

   initial begin
      logic [LIM_W-1:0] cfg[PHASES][4];
      cfg = '{'{512, 131072, 6554, 655},
              '{65535, 31'h7FFF_FFFF, 0, 0},
              '{0, 0, 0, 0},
              '{1, 1, 1, 31'h7FFF_FFFF},
              '{768, 65536, 31'h7FFF_FFFF, 10},
              '{65535, 0, 100, 1}};
      k_gain = GAIN_RST;
      v_max = MAX_SPEED_RST;
      arrive_tol = TOL_RST;
      dband = DEAD_BAND_RST;
      tgt_pos = '{0, 0, 0};
      cur_pos = '{0, 0, 0};
      pose_valid = 0;
      estop = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      add(REQ_STOP, 0, 0, 0, 1);
      add(REQ_TICK, 0, 0, 0, 0);
      add(REQ_TGT, 7 * Q1, 7 * Q1, 7 * Q1, 0);
      add(REQ_STOP, 0, 0, 0, 0);
      add(REQ_TICK, 0, 0, 0, 0);
      add(REQ_TGT, 5 * Q1, 5 * Q1, 5 * Q1, 1);
      add(REQ_POS, Q1, 2 * Q1, 3 * Q1, 0);
      add(REQ_TICK, $urandom, $urandom, $urandom, 1);
      add(REQ_TGT, 10 * Q1, -3 * Q1, 4 * Q1, 0);
      add(REQ_TICK, 0, 0, 0, 0);
      add(REQ_TGT, Q1 + 10000, 2 * Q1 + 300, 3 * Q1 - 300, 0);
      add(REQ_TICK, 0, 0, 0, 0);
      add(REQ_POS, PMIN, PMIN, PMIN, 0);
      add(REQ_TGT, PMAX, PMAX, PMAX, 0);
      add(REQ_TICK, 0, 0, 0, 0);
      add(REQ_POS, PMAX, PMAX, PMAX, 0);
      add(REQ_TGT, PMIN, PMIN, PMIN, 0);
      add(REQ_TICK, 0, 0, 0, 0);
      add(REQ_STOP, $urandom, $urandom, $urandom, 1);
      add(REQ_TGT, 0, 0, 0, 0);
      add(REQ_STOP, $urandom, $urandom, $urandom, 1);
      add(REQ_TICK, 0, 0, 0, 0);
      add(REQ_STOP, $urandom, $urandom, $urandom, 0);
      add(REQ_TICK, 0, 0, 0, 0);
      add(REQ_POS, 0, 0, 0, 1);
      add(REQ_TICK, 0, 0, 0, 0);
      add_random(ITEMS_PER_PHASE - 26);

      for (int p = 1; p < PHASES; p++) begin
         settle();
         write_csr(CSR_GAIN, cfg[p][0]);
         write_csr(CSR_MAX_SPEED, cfg[p][1]);
         write_csr(CSR_TOL, cfg[p][2]);
         write_csr(CSR_DEAD_BAND, cfg[p][3]);
         add_random(ITEMS_PER_PHASE);
         if (p == 1) hold_request = 1;
      end
      settle();
      if (mismatches == 0 && expected_cmds.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
